FILE: hdl/bb3_pkg.sv
package bb3_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int FIFO_DEPTH    = 8;

  localparam int WIDTH_REG_W = 11;
  localparam int HEIGHT_W    = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_ROW_W    = HEIGHT_W + 1;

  localparam logic CFG_WIDTH_IDX  = 1'b0;
  localparam logic CFG_HEIGHT_IDX = 1'b1;

  localparam logic [WIDTH_REG_W-1:0] WIDTH_RST  = 11'd1024;
  localparam logic [HEIGHT_W-1:0]    HEIGHT_RST = 16'd1024;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // rounding divide: q = ((2*sum + n) * ceil(2^20 / 2n)) >> 20, exact for num < 2^13
  localparam int SUM_W       = 12;
  localparam int NUM_W       = 13;
  localparam int RECIP_W     = 18;
  localparam int PROD_W      = NUM_W + RECIP_W;
  localparam int RECIP_SHIFT = 20;

  localparam logic [RECIP_W-1:0] RECIP_DIV4 = 18'd131072;
  localparam logic [RECIP_W-1:0] RECIP_DIV6 = 18'd87382;
  localparam logic [RECIP_W-1:0] RECIP_DIV9 = 18'd58255;

  typedef struct packed {
    logic       op;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } bb3_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;
  } bb3_out_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } bb3_rgb_t;

  typedef struct packed {
    bb3_rgb_t upper;
    bb3_rgb_t middle;
  } bb3_lines_t;

  typedef struct packed {
    logic use_top;
    logic use_bot;
    logic use_left;
    logic use_right;
    logic last;
  } bb3_ctl_t;

  function automatic logic [RECIP_W-1:0] div_recip(input logic rows3, input logic cols3);
    logic [RECIP_W-1:0] m;
    if (rows3 && cols3) begin
      m = RECIP_DIV9;
    end else if (rows3 || cols3) begin
      m = RECIP_DIV6;
    end else begin
      m = RECIP_DIV4;
    end
    return m;
  endfunction

  function automatic logic [3:0] div_count(input logic rows3, input logic cols3);
    logic [3:0] n;
    if (rows3 && cols3) begin
      n = 4'd9;
    end else if (rows3 || cols3) begin
      n = 4'd6;
    end else begin
      n = 4'd4;
    end
    return n;
  endfunction

endpackage

FILE: hdl/bb3_line_mem.sv
module bb3_line_mem
  import bb3_pkg::*;
#(
  parameter int DEPTH = MAX_WIDTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output bb3_lines_t       rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  bb3_lines_t       wr_data
);

  bb3_lines_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      // same-entry access returns the data being written
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

FILE: hdl/bb3_out_fifo.sv
module bb3_out_fifo
  import bb3_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bb3_out_t         push_item,
  input  logic             pop,
  output bb3_out_t         head,
  output logic [CNT_W-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  bb3_out_t store [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  assign head = store[rd_ptr];

endmodule

FILE: hdl/box_blur_3x3_rgb.sv
// 3x3 box blur over an RGB pixel stream in raster order.
// Input channel pix_valid/pix_ready/pix: op selects pixel or flush step.
// Output channel blur_valid/blur_ready/blur: one blurred pixel per item that
// completes a neighborhood; frame_end marks the last pixel of the frame.
// Config: cfg_we writes cfg_data into image_width (index 0) or image_height
// (index 1); write only between items.
// Throughput: one item per cycle while pix_ready is high. The line store is a
// single 48-bit RAM read and written once per item at the current column, one
// read and one write port per cycle.
// The result for a pixel is produced width+1 items after that pixel and then
// passes the RAM read, window sum and reciprocal multiply stages.
// After the last pixel send width+1 flush items to drain the last row.
// Reset clears the counters and the output queue and sets width and height
// to 1024; the line RAM is not cleared and the first item is taken in the
// cycle after reset.
// Stall: an 8-entry output queue absorbs results; pix_ready drops when queued
// plus in-flight items reach 8, and rises again as blur_ready drains it.
module box_blur_3x3_rgb
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pix_valid,
  output logic                  pix_ready,
  input  bb3_in_t               pix,
  output logic                  blur_valid,
  input  logic                  blur_ready,
  output bb3_out_t              blur,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW    = CW + 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  // configuration
  logic [WIDTH_REG_W-1:0] image_width;
  logic [HEIGHT_W-1:0]    image_height;
  logic [EW-1:0]          ew;
  logic [HEIGHT_W-1:0]    eh;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH_IDX:  image_width  <= cfg_data[WIDTH_REG_W-1:0];
        CFG_HEIGHT_IDX: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width < WIDTH_REG_W'(2)) begin
      ew = EW'(2);
    end else if (32'(image_width) > MAX_WIDTH) begin
      ew = EW'(MAX_WIDTH);
    end else begin
      ew = EW'(image_width);
    end
    eh = (image_height < HEIGHT_W'(2)) ? HEIGHT_W'(2) : image_height;
  end

  // position counters
  logic [CW-1:0]       in_column;
  logic [IN_ROW_W-1:0] in_row;
  logic [CW-1:0]       out_column;
  logic [HEIGHT_W-1:0] out_row;

  logic          accept, in_lt_h, skip, take, emit;
  logic [EW-1:0] in_col_inc, out_col_inc;
  logic          in_wrap, out_wrap, row_last, col_last, frame_last;
  bb3_rgb_t      pix_rgb;
  bb3_ctl_t      ctl;

  assign accept  = pix_valid && pix_ready;
  assign in_lt_h = in_row < {1'b0, eh};
  assign skip    = (pix.op == OP_FLUSH) && in_lt_h;
  assign take    = accept && !skip;
  assign emit    = (in_row >= IN_ROW_W'(2)) ||
                   ((in_row == IN_ROW_W'(1)) && (in_column != '0));

  assign in_col_inc  = {1'b0, in_column} + EW'(1);
  assign out_col_inc = {1'b0, out_column} + EW'(1);
  assign in_wrap     = in_col_inc >= ew;
  assign out_wrap    = out_col_inc >= ew;
  assign row_last    = out_row >= (eh - HEIGHT_W'(1));
  assign col_last    = {1'b0, out_column} >= (ew - EW'(1));
  assign frame_last  = row_last && col_last;

  always_comb begin
    if ((pix.op == OP_PIXEL) && in_lt_h) begin
      pix_rgb = '{r: pix.in_red, g: pix.in_green, b: pix.in_blue};
    end else begin
      pix_rgb = '0;
    end
    ctl.use_top   = out_row != '0;
    ctl.use_bot   = !row_last;
    ctl.use_left  = out_column != '0;
    ctl.use_right = !col_last;
    ctl.last      = frame_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (take) begin
      if (emit && frame_last) begin
        in_column  <= '0;
        in_row     <= '0;
        out_column <= '0;
        out_row    <= '0;
      end else begin
        in_column <= in_wrap ? '0 : in_col_inc[CW-1:0];
        if (in_wrap) begin
          in_row <= in_row + IN_ROW_W'(1);
        end
        if (emit) begin
          out_column <= out_wrap ? '0 : out_col_inc[CW-1:0];
          if (out_wrap) begin
            out_row <= out_row + HEIGHT_W'(1);
          end
        end
      end
    end
  end

  // stage 1: line RAM read data returns, window shifts, RAM written back
  logic       s1_valid, s1_emit;
  bb3_ctl_t   s1_ctl;
  bb3_rgb_t   s1_data;
  logic [CW-1:0] s1_addr;
  bb3_lines_t rd_lines;
  bb3_lines_t wr_lines;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_emit <= emit;
      s1_ctl  <= ctl;
      s1_data <= pix_rgb;
      s1_addr <= in_column;
    end
  end

  assign wr_lines = '{upper: rd_lines.middle, middle: s1_data};

  bb3_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (in_column),
    .rd_data (rd_lines),
    .wr_en   (s1_valid),
    .wr_addr (s1_addr),
    .wr_data (wr_lines)
  );

  bb3_rgb_t win [3][3];

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= rd_lines.upper;
      win[1][2] <= rd_lines.middle;
      win[2][2] <= s1_data;
    end
  end

  // stage 2: masked window sums
  logic            s2_valid;
  bb3_ctl_t        s2_ctl;
  logic [2:0]      row_use, col_use;
  logic [SUM_W-1:0] sum_r, sum_g, sum_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_ctl <= s1_ctl;
    end
  end

  always_comb begin
    row_use = {s2_ctl.use_bot, 1'b1, s2_ctl.use_top};
    col_use = {s2_ctl.use_right, 1'b1, s2_ctl.use_left};
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_use[r] && col_use[c]) begin
          sum_r = sum_r + SUM_W'(win[r][c].r);
          sum_g = sum_g + SUM_W'(win[r][c].g);
          sum_b = sum_b + SUM_W'(win[r][c].b);
        end
      end
    end
  end

  // stage 3: rounding divide by reciprocal multiply, into the output queue
  logic             s3_valid, s3_rows3, s3_cols3, s3_last;
  logic [SUM_W-1:0] s3_sum_r, s3_sum_g, s3_sum_b;
  logic [NUM_W-1:0] num_r, num_g, num_b;
  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod_r, prod_g, prod_b;
  bb3_out_t         res;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      s3_sum_r <= sum_r;
      s3_sum_g <= sum_g;
      s3_sum_b <= sum_b;
      s3_rows3 <= s2_ctl.use_top && s2_ctl.use_bot;
      s3_cols3 <= s2_ctl.use_left && s2_ctl.use_right;
      s3_last  <= s2_ctl.last;
    end
  end

  always_comb begin
    recip  = div_recip(s3_rows3, s3_cols3);
    num_r  = {s3_sum_r, 1'b0} + NUM_W'(div_count(s3_rows3, s3_cols3));
    num_g  = {s3_sum_g, 1'b0} + NUM_W'(div_count(s3_rows3, s3_cols3));
    num_b  = {s3_sum_b, 1'b0} + NUM_W'(div_count(s3_rows3, s3_cols3));
    prod_r = PROD_W'(num_r) * PROD_W'(recip);
    prod_g = PROD_W'(num_g) * PROD_W'(recip);
    prod_b = PROD_W'(num_b) * PROD_W'(recip);
    res.out_red   = prod_r[RECIP_SHIFT +: 8];
    res.out_green = prod_g[RECIP_SHIFT +: 8];
    res.out_blue  = prod_b[RECIP_SHIFT +: 8];
    res.frame_end = s3_last;
  end

  logic [CNT_W-1:0] q_count;
  logic [CNT_W:0]   credit;

  bb3_out_fifo #(
    .DEPTH (FIFO_DEPTH),
    .CNT_W (CNT_W)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s3_valid),
    .push_item (res),
    .pop       (blur_valid && blur_ready),
    .head      (blur),
    .count     (q_count)
  );

  assign blur_valid = q_count != '0;
  assign credit     = {1'b0, q_count} + (CNT_W + 1)'(s1_valid) +
                      (CNT_W + 1)'(s2_valid) + (CNT_W + 1)'(s3_valid);
  assign pix_ready  = credit < (CNT_W + 1)'(FIFO_DEPTH);

endmodule

FILE: hdl/bb3_checker.sv
module bb3_checker
  import bb3_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     pix_valid,
  input logic     pix_ready,
  input bb3_in_t  pix,
  input logic     blur_valid,
  input logic     blur_ready,
  input bb3_out_t blur
);

  // items taken but not yet answered; flush items count too
  logic [31:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 32'(pix_valid && pix_ready) - 32'(blur_valid && blur_ready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    blur_valid && !blur_ready |=> blur_valid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    blur_valid && !blur_ready |=> $stable(blur))
    else $error("output item changed while stalled");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !blur_valid && pix_ready)
    else $error("block not empty and ready after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    blur_valid && blur_ready |-> pending != '0)
    else $error("result delivered with no item outstanding");

  a_input_used: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready && (pix.op == OP_PIXEL) |=> pending != '0)
    else $error("accepted pixel not tracked");

endmodule

bind box_blur_3x3_rgb bb3_checker u_bb3_checker (.*);

FILE: sim/box_blur_3x3_rgb_tb.sv
module box_blur_3x3_rgb_tb;
  import bb3_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 12;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  pix_valid = 1'b0;
  logic                  pix_ready;
  bb3_in_t               pix = '0;
  logic                  blur_valid;
  logic                  blur_ready = 1'b0;
  bb3_out_t              blur;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  box_blur_3x3_rgb DUT (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .pix        (pix),
    .blur_valid (blur_valid),
    .blur_ready (blur_ready),
    .blur       (blur),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // blur predictor state
  logic [WIDTH_REG_W-1:0] width_reg;
  logic [HEIGHT_W-1:0]    height_reg;
  bb3_rgb_t               row_two_up [MAX_WIDTH_DEF];
  bb3_rgb_t               row_one_up [MAX_WIDTH_DEF];
  bb3_rgb_t               nbhd [3][3];
  int                     col_in, row_in, col_out, row_out;

  bb3_in_t  pix_pending [$];
  bb3_out_t expected_blur [$];
  bb3_out_t want;

  int errors = 0;
  int items_in = 0;
  int pixels_checked = 0;
  int frames_done = 0;
  int cycles = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_req = 0;
  int hold_seen;
  int hold_left;

  function automatic int eff_width();
    if (width_reg < 2) return 2;
    if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return width_reg;
  endfunction

  function automatic int eff_height();
    return (height_reg < 2) ? 2 : height_reg;
  endfunction

  function automatic logic [7:0] round_avg(input int sum, input int n);
    return 8'((2 * sum + n) / (2 * n));
  endfunction

  task automatic blur_predict(input bb3_in_t it);
    int       w, h, x, r, c, r0, r1, c0, c1, n, sr, sg, sb;
    bit       emit, last;
    bb3_rgb_t px;
    bb3_out_t o;
    w = eff_width();
    h = eff_height();
    if (it.op == OP_FLUSH && row_in < h) return;
    px = '0;
    if (it.op == OP_PIXEL && row_in < h) px = {it.in_red, it.in_green, it.in_blue};
    x = col_in % MAX_WIDTH_DEF;
    for (r = 0; r < 3; r++) begin
      nbhd[r][0] = nbhd[r][1];
      nbhd[r][1] = nbhd[r][2];
    end
    nbhd[0][2] = row_two_up[x];
    nbhd[1][2] = row_one_up[x];
    nbhd[2][2] = px;
    row_two_up[x] = row_one_up[x];
    row_one_up[x] = px;
    emit = row_in >= 2 || (row_in == 1 && col_in >= 1);
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
    end
    if (!emit) return;
    r0 = (row_out == 0) ? 1 : 0;
    r1 = (row_out >= h - 1) ? 1 : 2;
    c0 = (col_out == 0) ? 1 : 0;
    c1 = (col_out >= w - 1) ? 1 : 2;
    sr = 0;
    sg = 0;
    sb = 0;
    for (r = r0; r <= r1; r++) begin
      for (c = c0; c <= c1; c++) begin
        sr += nbhd[r][c].r;
        sg += nbhd[r][c].g;
        sb += nbhd[r][c].b;
      end
    end
    n = (r1 - r0 + 1) * (c1 - c0 + 1);
    last = row_out >= h - 1 && col_out >= w - 1;
    o.out_red   = round_avg(sr, n);
    o.out_green = round_avg(sg, n);
    o.out_blue  = round_avg(sb, n);
    o.frame_end = last;
    expected_blur.push_back(o);
    if (last) begin
      col_in = 0;
      row_in = 0;
      col_out = 0;
      row_out = 0;
    end else begin
      col_out++;
      if (col_out >= w) begin
        col_out = 0;
        row_out++;
      end
    end
  endtask

  function automatic void check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endfunction

  function automatic bb3_in_t mk_item(input logic op, input logic [7:0] r,
                                      input logic [7:0] g, input logic [7:0] b);
    bb3_in_t it;
    it.op       = op;
    it.in_red   = r;
    it.in_green = g;
    it.in_blue  = b;
    return it;
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic bb3_in_t rand_pixel();
    return mk_item(OP_PIXEL, rand_chan(), rand_chan(), rand_chan());
  endfunction

  task automatic queue_pixels(input int n);
    repeat (n) pix_pending.push_back(rand_pixel());
  endtask

  // full frame plus drain; noisy mixes in ignored flushes and pixels that drain
  task automatic queue_frame(input int w, input int h, input bit noisy);
    repeat (w * h) begin
      if (noisy && $urandom_range(99) < 5)
        pix_pending.push_back(mk_item(OP_FLUSH, rand_chan(), rand_chan(), rand_chan()));
      pix_pending.push_back(rand_pixel());
    end
    repeat (w + 1) begin
      if (noisy && $urandom_range(99) < 30) pix_pending.push_back(rand_pixel());
      else pix_pending.push_back(mk_item(OP_FLUSH, rand_chan(), rand_chan(), rand_chan()));
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pix_pending.size() != 0 || pix_valid || expected_blur.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WIDTH_IDX) width_reg = val[WIDTH_REG_W-1:0];
    else height_reg = val;
    @(negedge clk);
  endtask

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $error("timeout with %0d items pending, %0d results expected",
             pix_pending.size(), expected_blur.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
      pix       <= '0;
    end else begin
      if (pix_valid && pix_ready) begin
        blur_predict(pix);
        items_in++;
      end
      if (!pix_valid || pix_ready) begin
        if (pix_pending.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          pix       <= pix_pending.pop_front();
          pix_valid <= 1'b1;
        end else begin
          pix_valid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (rst) begin
      blur_ready <= 1'b0;
    end else begin
      if (blur_valid && blur_ready) begin
        if (expected_blur.size() == 0) begin
          $error("output item with none expected: %p", blur);
          errors++;
        end else begin
          want = expected_blur.pop_front();
          check_field("out_red", want.out_red, blur.out_red);
          check_field("out_green", want.out_green, blur.out_green);
          check_field("out_blue", want.out_blue, blur.out_blue);
          check_field("frame_end", want.frame_end, blur.frame_end);
          pixels_checked++;
          if (want.frame_end) frames_done++;
        end
      end
      blur_ready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  initial begin
    int w, h, p, i, n, c, r, cnt;
    for (i = 0; i < MAX_WIDTH_DEF; i++) begin
      row_two_up[i] = '0;
      row_one_up[i] = '0;
    end
    for (i = 0; i < 9; i++) nbhd[i / 3][i % 3] = '0;
    col_in = 0;
    row_in = 0;
    col_out = 0;
    row_out = 0;
    width_reg  = WIDTH_RST;
    height_reg = HEIGHT_RST;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // 2x2 frame, out-of-range registers saturate; corners only, half rounds up
    write_reg(CFG_WIDTH_IDX, 16'd1);
    write_reg(CFG_HEIGHT_IDX, 16'd0);
    pix_pending.push_back(mk_item(OP_FLUSH, 8'h5A, 8'hA5, 8'hFF));
    pix_pending.push_back(mk_item(OP_PIXEL, 8'hFF, 8'h00, 8'h01));
    pix_pending.push_back(mk_item(OP_PIXEL, 8'hFF, 8'h00, 8'h01));
    pix_pending.push_back(mk_item(OP_PIXEL, 8'h00, 8'hFF, 8'h00));
    pix_pending.push_back(mk_item(OP_PIXEL, 8'h00, 8'hFF, 8'h00));
    pix_pending.push_back(mk_item(OP_FLUSH, 8'h00, 8'h00, 8'h00));
    pix_pending.push_back(mk_item(OP_PIXEL, 8'hAA, 8'h55, 8'hFF));
    pix_pending.push_back(mk_item(OP_FLUSH, 8'hFF, 8'hFF, 8'hFF));
    wait_idle();

    // 3x3 frame: corner, edge and interior counts
    write_reg(CFG_WIDTH_IDX, 16'd3);
    write_reg(CFG_HEIGHT_IDX, 16'd3);
    for (i = 0; i < 9; i++)
      pix_pending.push_back(mk_item(OP_PIXEL, (i % 2) ? 8'hFF : 8'h00, 8'(i * 31),
                                    8'(255 - i * 17)));
    repeat (4) pix_pending.push_back(mk_item(OP_FLUSH, 8'h00, 8'h00, 8'h00));
    wait_idle();

    // registers changed mid-frame: width shrinks mid-row, then height ends the frame
    write_reg(CFG_WIDTH_IDX, 16'd5);
    write_reg(CFG_HEIGHT_IDX, 16'hFFFF);
    queue_pixels(19);
    wait_idle();
    write_reg(CFG_WIDTH_IDX, 16'd3);
    queue_pixels(7);
    wait_idle();
    write_reg(CFG_HEIGHT_IDX, 16'd5);
    w = eff_width();
    h = eff_height();
    c = col_in;
    r = row_in;
    n = 0;
    while (r < h) begin
      n++;
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
    end
    queue_pixels(n);
    repeat (3 * w + 4) pix_pending.push_back(mk_item(OP_FLUSH, 8'h00, 8'h00, 8'h00));
    wait_idle();

    // random frames under each idling mode
    for (p = 0; p < 4; p++) begin
      w = $urandom_range(2, 10);
      h = $urandom_range(2, 6);
      write_reg(CFG_WIDTH_IDX, (w == 2 && $urandom_range(1)) ? 16'($urandom_range(1)) : 16'(w));
      write_reg(CFG_HEIGHT_IDX, (h == 2 && $urandom_range(1)) ? 16'($urandom_range(1)) : 16'(h));
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 64; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 64; end
        default: begin src_idle_pct = 9; snk_stall_pct = 9; end
      endcase
      if (p == 0) hold_req++;
      cnt = 0;
      while (cnt < 70) begin
        queue_frame(w, h, 1'b1);
        cnt += w * h + w + 1;
      end
      wait_idle();
    end

    $display("%0d input items accepted over %0d frames, widths 2 to 10, registers moved mid-frame",
             items_in, frames_done);
    $display("%0d blurred pixels checked, %0d errors", pixels_checked, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
